@@ hw/rtl/fdep_pkg.sv @@
package fdep_pkg;

  localparam int NAME_MAX_DEF = 64;
  localparam int ENTRY_BYTES  = 32;
  localparam int UNITS        = 13;

  localparam logic [7:0] B_END     = 8'h00;
  localparam logic [7:0] B_DELETED = 8'hE5;
  localparam logic [7:0] B_KANJI   = 8'h05;
  localparam logic [7:0] B_SPACE   = 8'h20;
  localparam logic [7:0] ATTR_LFN  = 8'h0F;
  localparam logic [6:0] CH_UNDER  = 7'h5F;
  localparam logic [6:0] CH_DOT    = 7'h2E;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_END,
    ST_GLO,
    ST_GHI,
    ST_GUSE,
    ST_SRD,
    ST_SUSE,
    ST_LRD,
    ST_LUSE,
    ST_FIN
  } state_t;

  function automatic logic [6:0] map_unit(input logic [15:0] u);
    logic [6:0] c;
    if (u < 16'd128) begin
      c = u[6:0];
    end else begin
      case (u)
        16'h00E7: c = 7'h63;
        16'h00C7: c = 7'h43;
        16'h011F: c = 7'h67;
        16'h011E: c = 7'h47;
        16'h0131: c = 7'h69;
        16'h0130: c = 7'h49;
        16'h00F6: c = 7'h6F;
        16'h00D6: c = 7'h4F;
        16'h015F: c = 7'h73;
        16'h015E: c = 7'h53;
        16'h00FC: c = 7'h75;
        16'h00DC: c = 7'h55;
        default:  c = CH_UNDER;
      endcase
    end
    return c;
  endfunction

  function automatic logic [4:0] unit_off(input logic [3:0] i);
    logic [4:0] o;
    if (i < 4'd5) begin
      o = 5'd1 + {i, 1'b0};
    end else if (i < 4'd11) begin
      o = 5'd14 + {i - 4'd5, 1'b0};
    end else begin
      o = 5'd28 + {i - 4'd11, 1'b0};
    end
    return o;
  endfunction

  function automatic logic [6:0] short_char(input logic [7:0] b, input logic first);
    logic [6:0] c;
    if ((first && b == B_KANJI) || b[7]) begin
      c = CH_UNDER;
    end else begin
      c = b[6:0];
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/fdep_ram.sv @@
module fdep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/fat_directory_entry_parser_unit.sv @@
// Directory bytes are taken one per cycle while the parser is collecting an entry; in_stall
// is high from the cycle after the 32nd byte of an entry that produces output or long-name
// data until its results are all produced. A long-name part then stores each UTF-16 unit
// with two reads of the entry memory and one write of the name memory, up to 13 units; a
// file or directory entry reads the entry or name memory and pushes each name character,
// skips blanks, places the dot, closes and waits on out_stall; end of directory gives one end
// word. There is no clearing pass after reset.
module fat_directory_entry_parser_unit
  import fdep_pkg::*;
#(
  parameter int NAME_MAX = fdep_pkg::NAME_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_listing,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [6:0]  out_name_char,
  output logic        out_char_valid,
  output logic        out_last,
  output logic [7:0]  out_attr,
  output logic        out_is_dir,
  output logic [31:0] out_first_cluster,
  output logic [31:0] out_file_size,
  output logic [15:0] out_mod_time,
  output logic [15:0] out_mod_date
);

  localparam int LW = $clog2(NAME_MAX);

  state_t state_r, state_nxt;
  logic [4:0]          pos_r, pos_nxt;
  logic                ended_r, ended_nxt;
  logic                active_r, active_nxt;
  logic [7:0]          lsum_r, lsum_nxt;
  logic [NAME_MAX-1:0] written_r, written_nxt;

  logic [7:0]  first_r, attr_r, chk_r, csum_r;
  logic [15:0] clhi_r, cllo_r, time_r, date_r;
  logic [31:0] size_r;

  logic [3:0]  idx_r, idx_nxt;
  logic [7:0]  lo_r, lo_nxt;
  logic [8:0]  upos_r, upos_nxt;
  logic        dot_r, dot_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic        hold_v_r, hold_v_nxt;
  logic [6:0]  hold_c_r, hold_c_nxt;

  logic        out_v_r, out_v_nxt;

  logic        in_acc, cap_en, can_load;
  logic [4:0]  pe;
  logic        ee;
  logic        load, load_kind, load_cv, load_last;
  logic [6:0]  load_char;
  logic        push, push_ok;
  logic [6:0]  push_c;
  logic        act;
  logic [7:0]  sref;
  logic [15:0] u;

  logic        e_we, e_re, l_we, l_re;
  logic [4:0]  e_raddr;
  logic [7:0]  e_rd;
  logic [6:0]  l_rd, l_wdata;

  fdep_ram #(.WIDTH(8), .DEPTH(ENTRY_BYTES)) u_entry (
    .clk(clk), .we(e_we), .waddr(pe), .wdata(in_data_byte),
    .re(e_re), .raddr(e_raddr), .rdata(e_rd)
  );

  fdep_ram #(.WIDTH(7), .DEPTH(NAME_MAX)) u_lname (
    .clk(clk), .we(l_we), .waddr(upos_r[LW-1:0]), .wdata(l_wdata),
    .re(l_re), .raddr(len_r), .rdata(l_rd)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign pe       = in_start_listing ? 5'd0 : pos_r;
  assign ee       = in_start_listing ? 1'b0 : ended_r;
  assign cap_en   = in_acc && !ee;
  assign e_we     = cap_en;
  assign can_load = !out_v_r || !out_stall;
  assign push_ok  = !hold_v_r || can_load;
  assign u        = {e_rd, lo_r};
  assign l_wdata  = map_unit(u);

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    ended_nxt   = ended_r;
    active_nxt  = active_r;
    lsum_nxt    = lsum_r;
    written_nxt = written_r;
    idx_nxt     = idx_r;
    lo_nxt      = lo_r;
    upos_nxt    = upos_r;
    dot_nxt     = dot_r;
    len_nxt     = len_r;
    hold_v_nxt  = hold_v_r;
    hold_c_nxt  = hold_c_r;
    out_v_nxt   = out_v_r && out_stall;
    load        = 1'b0;
    load_kind   = 1'b0;
    load_char   = 7'd0;
    load_cv     = 1'b0;
    load_last   = 1'b0;
    push        = 1'b0;
    push_c      = 7'd0;
    e_re        = 1'b0;
    e_raddr     = 5'd0;
    l_we        = 1'b0;
    l_re        = 1'b0;
    act         = 1'b0;
    sref        = 8'd0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_start_listing) begin
            pos_nxt     = 5'd0;
            ended_nxt   = 1'b0;
            active_nxt  = 1'b0;
            written_nxt = '0;
          end
          if (!ee) begin
            if (pe != 5'd31) begin
              pos_nxt = pe + 5'd1;
            end else begin
              pos_nxt = 5'd0;
              if (first_r == B_END) begin
                ended_nxt = 1'b1;
                state_nxt = ST_END;
              end else if (first_r == B_DELETED) begin
                state_nxt = ST_IDLE;
              end else if (attr_r == ATTR_LFN) begin
                act  = active_nxt;
                sref = lsum_r;
                if (first_r[6]) begin
                  act         = 1'b1;
                  lsum_nxt    = chk_r;
                  sref        = chk_r;
                  written_nxt = '0;
                end
                if (chk_r != sref) begin
                  act = 1'b0;
                end
                active_nxt = act;
                if (act && first_r[4:0] != 5'd0) begin
                  upos_nxt  = 9'(first_r[4:0] - 5'd1) * 9'd13;
                  idx_nxt   = 4'd0;
                  state_nxt = ST_GLO;
                end
              end else if (attr_r[3]) begin
                active_nxt = 1'b0;
              end else begin
                hold_v_nxt = 1'b0;
                if (active_nxt && written_nxt[0] && csum_r == lsum_r) begin
                  len_nxt   = '0;
                  state_nxt = ST_LRD;
                end else begin
                  idx_nxt   = 4'd0;
                  dot_nxt   = 1'b0;
                  state_nxt = ST_SRD;
                end
              end
            end
          end
        end
      end
      ST_END: begin
        if (can_load) begin
          load      = 1'b1;
          load_kind = 1'b1;
          load_last = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_GLO: begin
        e_re      = 1'b1;
        e_raddr   = unit_off(idx_r);
        state_nxt = ST_GHI;
      end
      ST_GHI: begin
        lo_nxt    = e_rd;
        e_re      = 1'b1;
        e_raddr   = unit_off(idx_r) + 5'd1;
        state_nxt = ST_GUSE;
      end
      ST_GUSE: begin
        if (u == 16'h0000 || u == 16'hFFFF) begin
          state_nxt = ST_IDLE;
        end else begin
          if (upos_r < 9'(NAME_MAX)) begin
            l_we = 1'b1;
            written_nxt[upos_r[LW-1:0]] = 1'b1;
          end
          upos_nxt = upos_r + 9'd1;
          idx_nxt  = idx_r + 4'd1;
          state_nxt = (idx_r == 4'(UNITS - 1)) ? ST_IDLE : ST_GLO;
        end
      end
      ST_SRD: begin
        e_re      = 1'b1;
        e_raddr   = {1'b0, idx_r};
        state_nxt = ST_SUSE;
      end
      ST_SUSE: begin
        if (idx_r < 4'd8) begin
          if (e_rd == B_SPACE) begin
            idx_nxt   = 4'd8;
            state_nxt = ST_SRD;
          end else begin
            push   = 1'b1;
            push_c = short_char(e_rd, idx_r == 4'd0);
            if (push_ok) begin
              idx_nxt   = idx_r + 4'd1;
              state_nxt = ST_SRD;
            end
          end
        end else if (idx_r == 4'd8 && !dot_r) begin
          if (e_rd == B_SPACE) begin
            state_nxt = ST_FIN;
          end else begin
            push   = 1'b1;
            push_c = CH_DOT;
            if (push_ok) begin
              dot_nxt = 1'b1;
            end
          end
        end else begin
          if (e_rd == B_SPACE) begin
            state_nxt = ST_FIN;
          end else begin
            push   = 1'b1;
            push_c = short_char(e_rd, 1'b0);
            if (push_ok) begin
              idx_nxt   = idx_r + 4'd1;
              state_nxt = (idx_r == 4'd10) ? ST_FIN : ST_SRD;
            end
          end
        end
      end
      ST_LRD: begin
        if ((LW+1)'(len_r) + (LW+1)'(1) < (LW+1)'(NAME_MAX) && written_r[len_r]) begin
          l_re      = 1'b1;
          state_nxt = ST_LUSE;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_LUSE: begin
        push   = 1'b1;
        push_c = l_rd;
        if (push_ok) begin
          len_nxt   = len_r + LW'(1);
          state_nxt = ST_LRD;
        end
      end
      ST_FIN: begin
        if (can_load) begin
          load        = 1'b1;
          load_char   = hold_v_r ? hold_c_r : 7'd0;
          load_cv     = hold_v_r;
          load_last   = 1'b1;
          hold_v_nxt  = 1'b0;
          active_nxt  = 1'b0;
          written_nxt = '0;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (push && push_ok) begin
      if (hold_v_r) begin
        load      = 1'b1;
        load_char = hold_c_r;
        load_cv   = 1'b1;
      end
      hold_v_nxt = 1'b1;
      hold_c_nxt = push_c;
    end
    if (load) begin
      out_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pos_r     <= 5'd0;
      ended_r   <= 1'b0;
      active_r  <= 1'b0;
      lsum_r    <= 8'd0;
      written_r <= '0;
      hold_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      ended_r   <= ended_nxt;
      active_r  <= active_nxt;
      lsum_r    <= lsum_nxt;
      written_r <= written_nxt;
      hold_v_r  <= hold_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    lo_r     <= lo_nxt;
    upos_r   <= upos_nxt;
    dot_r    <= dot_nxt;
    len_r    <= len_nxt;
    hold_c_r <= hold_c_nxt;
    if (cap_en) begin
      case (pe)
        5'd0:  first_r       <= in_data_byte;
        5'd11: attr_r        <= in_data_byte;
        5'd13: chk_r         <= in_data_byte;
        5'd20: clhi_r[7:0]   <= in_data_byte;
        5'd21: clhi_r[15:8]  <= in_data_byte;
        5'd22: time_r[7:0]   <= in_data_byte;
        5'd23: time_r[15:8]  <= in_data_byte;
        5'd24: date_r[7:0]   <= in_data_byte;
        5'd25: date_r[15:8]  <= in_data_byte;
        5'd26: cllo_r[7:0]   <= in_data_byte;
        5'd27: cllo_r[15:8]  <= in_data_byte;
        5'd28: size_r[7:0]   <= in_data_byte;
        5'd29: size_r[15:8]  <= in_data_byte;
        5'd30: size_r[23:16] <= in_data_byte;
        5'd31: size_r[31:24] <= in_data_byte;
        default: begin
        end
      endcase
      if (pe == 5'd0) begin
        csum_r <= in_data_byte;
      end else if (pe < 5'd11) begin
        csum_r <= {csum_r[0], csum_r[7:1]} + in_data_byte;
      end
    end
    if (load) begin
      out_kind       <= load_kind;
      out_name_char  <= load_char;
      out_char_valid <= load_cv;
      out_last       <= load_last;
      out_attr          <= load_kind ? 8'd0 : attr_r;
      out_is_dir        <= load_kind ? 1'b0 : attr_r[4];
      out_first_cluster <= load_kind ? 32'd0 : {clhi_r, cllo_r};
      out_file_size     <= load_kind ? 32'd0 : size_r;
      out_mod_time      <= load_kind ? 16'd0 : time_r;
      out_mod_date      <= load_kind ? 16'd0 : date_r;
    end
  end

  assign out_valid = out_v_r;

endmodule

@@ dv/fat_directory_entry_parser_checker.sv @@
module fat_directory_entry_parser_checker
  import fdep_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_listing,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_kind,
  input  logic [6:0]  out_name_char,
  input  logic        out_char_valid,
  input  logic        out_last,
  input  logic [7:0]  out_attr,
  input  logic        out_is_dir,
  input  logic [31:0] out_first_cluster,
  input  logic [31:0] out_file_size,
  input  logic [15:0] out_mod_time,
  input  logic [15:0] out_mod_date,
  output int          failures,
  output int          pending
);

  localparam int NAME_LIMIT = NAME_MAX_DEF;

  typedef struct packed {
    logic        kind;
    logic [6:0]  name_char;
    logic        char_valid;
    logic        last;
    logic [7:0]  attr;
    logic        is_dir;
    logic [31:0] first_cluster;
    logic [31:0] file_size;
    logic [15:0] mod_time;
    logic [15:0] mod_date;
  } dir_word_t;

  dir_word_t  expected_words[$];
  logic [7:0] entry[32];
  logic [4:0] fill_pos;
  logic [6:0] lname[64];
  logic [63:0] lname_set;
  logic       lname_on;
  logic [7:0] lname_sum;
  logic       ended;

  function automatic logic [15:0] word_at(int at);
    return {entry[at+1], entry[at]};
  endfunction

  function automatic logic [6:0] fold_unit(logic [15:0] u);
    if (u < 16'd128) return u[6:0];
    case (u)
      16'h00E7: return 7'h63;
      16'h00C7: return 7'h43;
      16'h011F: return 7'h67;
      16'h011E: return 7'h47;
      16'h0131: return 7'h69;
      16'h0130: return 7'h49;
      16'h00F6: return 7'h6F;
      16'h00D6: return 7'h4F;
      16'h015F: return 7'h73;
      16'h015E: return 7'h53;
      16'h00FC: return 7'h75;
      16'h00DC: return 7'h55;
      default:  return CH_UNDER;
    endcase
  endfunction

  function automatic logic [7:0] name_sum();
    logic [7:0] s;
    s = 8'h00;
    for (int i = 0; i < 11; i++) s = {s[0], s[7:1]} + entry[i];
    return s;
  endfunction

  function automatic logic [6:0] base_char(int i);
    logic [7:0] b;
    b = entry[i];
    if (i == 0 && b == B_KANJI) b = B_DELETED;
    return b[7] ? CH_UNDER : b[6:0];
  endfunction

  task automatic push_word(logic kind, logic [6:0] ch, logic cv, logic lst);
    dir_word_t w;
    w = '0;
    w.kind = kind;
    w.name_char = ch;
    w.char_valid = cv;
    w.last = lst;
    if (!kind) begin
      w.attr = entry[11];
      w.is_dir = entry[11][4];
      w.first_cluster = {word_at(20), word_at(26)};
      w.file_size = {word_at(30), word_at(28)};
      w.mod_time = word_at(22);
      w.mod_date = word_at(24);
    end
    expected_words.push_back(w);
  endtask

  task automatic gather_part();
    logic [7:0] seq;
    logic [7:0] chk;
    logic [15:0] u;
    int n, off, p;
    seq = entry[0];
    chk = entry[13];
    if (seq[6]) begin
      lname_on = 1'b1;
      lname_sum = chk;
      lname_set = '0;
    end
    if (chk != lname_sum) lname_on = 1'b0;
    if (!lname_on) return;
    n = int'(seq[4:0]);
    if (n == 0) return;
    for (int i = 0; i < 13; i++) begin
      off = (i < 5) ? 1 + 2 * i : (i < 11) ? 14 + 2 * (i - 5) : 28 + 2 * (i - 11);
      u = word_at(off);
      p = (n - 1) * 13 + i;
      if (u == 16'h0000 || u == 16'hFFFF) break;
      if (p < NAME_LIMIT) begin
        lname[p] = fold_unit(u);
        lname_set[p] = 1'b1;
      end
    end
  endtask

  task automatic emit_name();
    logic [6:0] nm[64];
    int len;
    len = 0;
    if (lname_on && lname_set[0] && name_sum() == lname_sum) begin
      while (len < 64 && len + 1 < NAME_LIMIT && lname_set[len]) begin
        nm[len] = lname[len];
        len++;
      end
    end else begin
      for (int i = 0; i < 8 && entry[i] != B_SPACE; i++) nm[len++] = base_char(i);
      if (entry[8] != B_SPACE) begin
        nm[len++] = CH_DOT;
        for (int i = 8; i < 11 && entry[i] != B_SPACE; i++) nm[len++] = base_char(i);
      end
    end
    lname_on = 1'b0;
    lname_set = '0;
    if (len == 0) push_word(1'b0, 7'd0, 1'b0, 1'b1);
    for (int k = 0; k < len; k++) push_word(1'b0, nm[k], 1'b1, k + 1 == len);
  endtask

  task automatic take_byte(logic [7:0] b, logic s);
    if (s) begin
      fill_pos = '0;
      lname_set = '0;
      lname_on = 1'b0;
      ended = 1'b0;
    end
    if (ended) return;
    entry[fill_pos] = b;
    if (fill_pos != 5'd31) begin
      fill_pos++;
      return;
    end
    fill_pos = '0;
    if (entry[0] == B_END) begin
      ended = 1'b1;
      push_word(1'b1, 7'd0, 1'b0, 1'b1);
    end else if (entry[0] == B_DELETED) begin
    end else if (entry[11] == ATTR_LFN) begin
      gather_part();
    end else if (entry[11][3]) begin
      lname_on = 1'b0;
    end else begin
      emit_name();
    end
  endtask

  task automatic check_field(string nm, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t mismatch %s expected %0h actual %0h", $time, nm, e, a);
      failures++;
    end
  endtask

  initial begin
    failures = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    dir_word_t w;
    if (!rst_n) begin
      fill_pos = '0;
      lname_set = '0;
      lname_on = 1'b0;
      lname_sum = '0;
      ended = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t unexpected word kind %0d char %0h", $time, out_kind, out_name_char);
          failures++;
        end else begin
          w = expected_words.pop_front();
          check_field("kind", 32'(w.kind), 32'(out_kind));
          check_field("name_char", 32'(w.name_char), 32'(out_name_char));
          check_field("char_valid", 32'(w.char_valid), 32'(out_char_valid));
          check_field("last", 32'(w.last), 32'(out_last));
          check_field("attr", 32'(w.attr), 32'(out_attr));
          check_field("is_dir", 32'(w.is_dir), 32'(out_is_dir));
          check_field("first_cluster", w.first_cluster, out_first_cluster);
          check_field("file_size", w.file_size, out_file_size);
          check_field("mod_time", 32'(w.mod_time), 32'(out_mod_time));
          check_field("mod_date", 32'(w.mod_date), 32'(out_mod_date));
        end
      end
      if (in_valid && !in_stall) take_byte(in_data_byte, in_start_listing);
    end
    pending <= expected_words.size();
  end

endmodule

@@ dv/tb_fat_directory_entry_parser_unit.sv @@
module tb_fat_directory_entry_parser_unit;
  import fdep_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_start_listing;
  logic        out_valid;
  logic        out_stall;
  logic        out_kind;
  logic [6:0]  out_name_char;
  logic        out_char_valid;
  logic        out_last;
  logic [7:0]  out_attr;
  logic        out_is_dir;
  logic [31:0] out_first_cluster;
  logic [31:0] out_file_size;
  logic [15:0] out_mod_time;
  logic [15:0] out_mod_date;
  int          failures;
  int          pending;

  logic [7:0]  ent[32];
  logic [7:0]  short_name[11];
  int          sent;
  logic        calm;
  logic        hold_req;
  logic        need_start;

  fat_directory_entry_parser_unit dut (.*);

  fat_directory_entry_parser_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("FAIL");
    $finish;
  end

  // receiver side
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (int i = 0; i < 400; i++) @(posedge clk);
        hold_req = 1'b0;
      end
      out_stall <= !calm && $urandom_range(0, 99) < 37;
    end
  end

  task automatic send_word(logic [7:0] b, logic s);
    calm = (sent > 120 && sent < 200);
    while (!calm && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_start_listing <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_entry();
    for (int i = 0; i < 32; i++) begin
      send_word(ent[i], i == 0 && need_start);
    end
    need_start = 1'b0;
  endtask

  function automatic logic [7:0] sum_of_name();
    logic [7:0] s;
    s = 8'h00;
    for (int i = 0; i < 11; i++) s = {s[0], s[7:1]} + short_name[i];
    return s;
  endfunction

  task automatic random_tail();
    for (int i = 11; i < 32; i++) ent[i] = 8'($urandom);
  endtask

  // mode 0 plain, 1 blank, 2 high bytes, 3 leading 05, 4 random
  task automatic pick_name(int mode);
    int nl, el;
    nl = $urandom_range(1, 8);
    el = $urandom_range(0, 3);
    for (int i = 0; i < 11; i++) begin
      if (i < 8) short_name[i] = (i < nl) ? 8'(8'h41 + $urandom_range(0, 25)) : B_SPACE;
      else short_name[i] = (i - 8 < el) ? 8'(8'h30 + $urandom_range(0, 9)) : B_SPACE;
    end
    case (mode)
      1: for (int i = 0; i < 11; i++) short_name[i] = B_SPACE;
      2: begin
        short_name[0] = 8'h80 | 8'($urandom);
        short_name[8] = 8'hFF;
      end
      3: short_name[0] = B_KANJI;
      4: for (int i = 0; i < 11; i++) short_name[i] = 8'($urandom_range(1, 255));
      default: ;
    endcase
    if (short_name[0] == B_END || short_name[0] == B_DELETED) short_name[0] = 8'h5A;
  endtask

  task automatic make_file();
    random_tail();
    for (int i = 0; i < 11; i++) ent[i] = short_name[i];
    ent[11] = 8'($urandom) & 8'hF7;
  endtask

  function automatic logic [15:0] pick_unit();
    logic [15:0] tk[12] = '{16'h00E7, 16'h00C7, 16'h011F, 16'h011E, 16'h0131, 16'h0130,
                            16'h00F6, 16'h00D6, 16'h015F, 16'h015E, 16'h00FC, 16'h00DC};
    int r;
    logic [15:0] u;
    r = $urandom_range(0, 99);
    if (r < 60) u = 16'($urandom_range(16'h21, 16'h7E));
    else if (r < 80) u = tk[$urandom_range(0, 11)];
    else u = 16'($urandom_range(1, 16'hFFFE));
    return u;
  endfunction

  task automatic make_part(logic [7:0] seq, logic [7:0] sum, int len);
    int off;
    logic [15:0] u;
    random_tail();
    for (int i = 0; i < 11; i++) ent[i] = 8'($urandom);
    ent[0] = seq;
    ent[11] = ATTR_LFN;
    ent[13] = sum;
    for (int i = 0; i < 13; i++) begin
      off = (i < 5) ? 1 + 2 * i : (i < 11) ? 14 + 2 * (i - 5) : 28 + 2 * (i - 11);
      u = (i < len) ? pick_unit() : (i == len) ? 16'h0000 : 16'hFFFF;
      ent[off] = u[7:0];
      ent[off+1] = u[15:8];
    end
  endtask

  task automatic long_name_file(bit broken);
    int n, len;
    logic [7:0] seq;
    logic [7:0] sum;
    pick_name($urandom_range(0, 4));
    sum = sum_of_name();
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : $urandom_range(1, 2);
    for (int k = n; k >= 1; k--) begin
      seq = 8'(k);
      if (k == n) seq[6] = 1'b1;
      len = (k == n) ? $urandom_range(1, 13) : 13;
      if (k != n && $urandom_range(0, 19) == 0) len = $urandom_range(0, 12);
      if (broken) begin
        case ($urandom_range(0, 4))
          0: seq = seq & 8'hE0;
          1: sum = sum ^ (8'h01 << $urandom_range(0, 7));
          2: seq[6] = ~seq[6];
          default: ;
        endcase
      end
      make_part(seq, sum, len);
      if (seq[7:5] == 3'b111) ent[0] = seq & 8'h7F;
      send_entry();
    end
    if (broken && $urandom_range(0, 1)) short_name[10] = short_name[10] ^ 8'h01;
    make_file();
    send_entry();
  endtask

  task automatic end_listing();
    random_tail();
    ent[0] = B_END;
    for (int i = 1; i < 11; i++) ent[i] = 8'($urandom);
    send_entry();
    repeat ($urandom_range(1, 40)) send_word(8'($urandom), 1'b0);
    need_start = 1'b1;
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_start_listing = 1'b0;
    calm = 1'b0;
    hold_req = 1'b0;
    need_start = 1'b1;
    sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    pick_name(3); make_file(); ent[11] = 8'h10; send_entry();
    pick_name(1); make_file(); send_entry();
    pick_name(0); make_file(); ent[0] = B_DELETED; send_entry();
    pick_name(0); make_file(); ent[11] = 8'h08; send_entry();
    long_name_file(1'b0);
    make_part(8'h45, 8'h00, 13); send_entry();
    pick_name(2); make_file(); ent[11] = 8'hF7; send_entry();

    // long receiver hold-off while the sender keeps feeding
    hold_req = 1'b1;
    pick_name(0); make_file(); send_entry();
    end_listing();

    // pause until the unit has emptied
    in_valid <= 1'b0;
    drain();

    while (sent < 310) begin
      r = $urandom_range(0, 99);
      if (r < 45) long_name_file($urandom_range(0, 99) < 20);
      else if (r < 70) begin
        pick_name($urandom_range(0, 4));
        make_file();
        send_entry();
      end else if (r < 77) begin
        pick_name(0); make_file(); ent[0] = B_DELETED; send_entry();
      end else if (r < 83) begin
        pick_name(0); make_file(); ent[11] = (8'($urandom) & 8'hF7) | 8'h08;
        if (ent[11] == ATTR_LFN) ent[11] = 8'h08;
        send_entry();
      end else if (r < 89) begin
        for (int i = 0; i < 32; i++) ent[i] = 8'($urandom);
        send_entry();
      end else if (r < 94) end_listing();
      else begin
        repeat ($urandom_range(1, 31)) send_word(8'($urandom), 1'b0);
        need_start = 1'b1;
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    drain();
    repeat (300) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ fat_directory_entry_parser_unit.f @@
hw/rtl/fdep_pkg.sv
hw/rtl/fdep_ram.sv
hw/rtl/fat_directory_entry_parser_unit.sv
dv/fat_directory_entry_parser_checker.sv
dv/tb_fat_directory_entry_parser_unit.sv
